### design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared clocked assertion forms for the pooling unit.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds on a rising edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### design/mpwa_pkg.sv
// ----------------------------------------------------------------------------
// Max pooling with argmax package
// Field widths and configuration register indexes.
// ----------------------------------------------------------------------------
package mpwa_pkg;

  localparam int VAL_W      = 16;   // signed Q8.8 sample
  localparam int COORD_W    = 10;   // row and column fields of a result
  localparam int PLANE_W    = 12;   // plane field of a result
  localparam int CFG_DATA_W = 13;   // widest register
  localparam int CFG_IDX_W  = 2;
  localparam int WIN_CFG_W  = 4;
  localparam int LINE_CFG_W = 11;
  localparam int PLANE_MAX  = 4096;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_SIZE = 2'd0,
    REG_PLANE_ROWS  = 2'd1,
    REG_PLANE_COLS  = 2'd2,
    REG_PLANE_COUNT = 2'd3
  } cfg_reg_t;

endpackage

### design/max_pool_with_argmax_unit.sv
// ----------------------------------------------------------------------------
// Max pooling with argmax unit
// Streaming square-window max pooling that reports the maximum's position.
// ----------------------------------------------------------------------------
// Usage:
//   Samples enter on in_sample with in_valid/in_ready, plane by plane, rows
//   outer and columns inner. Window side and stride, plane size and plane
//   count come from the cfg_ write port; write it only while the unit is
//   idle. Every write restarts the frame at row 0, column 0, plane 0.
//   When the last sample of a window is taken, one result leaves on the out_
//   channel: the maximum, pooled row/column, plane and source row/column.
//   Windows on the right and bottom edges are partial; ties keep the
//   earliest sample.
//   Path: a taken sample is held in the input stage, which holds the
//   line-store read, and a window's result then loads the output register.
//   Throughput: one sample per cycle while no result stalls, limited by the
//   single read-modify-write of the line store per sample; a write that a
//   following sample needs is forwarded.
//   Reset: counters return to zero, registers to window 2, 32 x 32, one
//   plane. The line store is not cleared: each window seeds its entry.
//   Stall: a result waits in the output register while samples that close
//   no window keep flowing; in_ready drops only while the input stage holds
//   the next window-closing sample, until out_ready returns.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module max_pool_with_argmax_unit
  import mpwa_pkg::*;
#(
  parameter int MAX_LINE   = 1024,
  parameter int MAX_WINDOW = 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // configuration
  input  logic                     cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data,
  // sample channel
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [VAL_W-1:0]  in_sample,
  // result channel
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [VAL_W-1:0]  out_pooled_value,
  output logic [COORD_W-1:0]       out_pooled_row,
  output logic [COORD_W-1:0]       out_pooled_col,
  output logic [PLANE_W-1:0]       out_plane_index,
  output logic [COORD_W-1:0]       out_source_row,
  output logic [COORD_W-1:0]       out_source_col
);

  localparam int CW = $clog2(MAX_LINE);
  localparam int WW = $clog2(MAX_WINDOW);
  localparam int MW = VAL_W + 2 * WW;

  // Effective register values, minus one
  logic [WW-1:0]      win_m1_r;
  logic [CW-1:0]      rows_m1_r;
  logic [CW-1:0]      cols_m1_r;
  logic [PLANE_W-1:0] planes_m1_r;

  // Position counters
  logic [CW-1:0]      row_r, col_r;
  logic [CW-1:0]      wrow_r, wcol_r;
  logic [WW-1:0]      riw_r, ciw_r;
  logic [PLANE_W-1:0] plane_r;

  // Input stage
  logic                    s1_valid_r;
  logic signed [VAL_W-1:0] s1_sample_r;
  logic [CW-1:0]           s1_slot_r;
  logic [WW-1:0]           s1_riw_r, s1_ciw_r;
  logic                    s1_seed_r;
  logic                    s1_last_r;
  logic [CW-1:0]           s1_base_row_r, s1_base_col_r;
  logic [CW-1:0]           s1_wrow_r;
  logic [PLANE_W-1:0]      s1_plane_r;

  // Line store and forwarding
  logic [MW-1:0] line_mem [MAX_LINE];
  logic [MW-1:0] rd_word_r;
  logic [MW-1:0] byp_word_r;
  logic          byp_hit_r;

  // Output register
  logic                    out_valid_r;
  logic signed [VAL_W-1:0] out_value_r;
  logic [COORD_W-1:0]      out_prow_r, out_pcol_r, out_srow_r, out_scol_r;
  logic [PLANE_W-1:0]      out_plane_r;

  logic                    in_fire;
  logic                    s1_adv;
  logic                    out_load;
  logic                    last_row, last_col;
  logic [MW-1:0]           old_word;
  logic signed [VAL_W-1:0] old_val;
  logic signed [VAL_W-1:0] new_val;
  logic [WW-1:0]           new_off_row, new_off_col;
  logic [MW-1:0]           new_word;

  function automatic logic [WW-1:0] clamp_win(input logic [WIN_CFG_W-1:0] v);
    logic [WW-1:0] res;
    if (v == '0) begin
      res = '0;
    end else if (int'(v) > MAX_WINDOW) begin
      res = WW'(MAX_WINDOW - 1);
    end else begin
      res = WW'(v - 1'b1);
    end
    return res;
  endfunction

  function automatic logic [CW-1:0] clamp_line(input logic [LINE_CFG_W-1:0] v);
    logic [CW-1:0] res;
    if (v == '0) begin
      res = '0;
    end else if (int'(v) > MAX_LINE) begin
      res = CW'(MAX_LINE - 1);
    end else begin
      res = CW'(v - 1'b1);
    end
    return res;
  endfunction

  function automatic logic [PLANE_W-1:0] clamp_plane(input logic [CFG_DATA_W-1:0] v);
    logic [PLANE_W-1:0] res;
    if (v == '0) begin
      res = '0;
    end else if (int'(v) > PLANE_MAX) begin
      res = PLANE_W'(PLANE_MAX - 1);
    end else begin
      res = PLANE_W'(v - 1'b1);
    end
    return res;
  endfunction

  // Handshake
  assign s1_adv   = s1_valid_r && (!s1_last_r || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_fire  = in_valid && in_ready;
  assign out_load = s1_adv && s1_last_r;

  // Window edge flags of the current sample
  assign last_row = (riw_r == win_m1_r) || (row_r == rows_m1_r);
  assign last_col = (ciw_r == win_m1_r) || (col_r == cols_m1_r);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_m1_r    <= WW'(1);
      rows_m1_r   <= CW'(31);
      cols_m1_r   <= CW'(31);
      planes_m1_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_WINDOW_SIZE: win_m1_r    <= clamp_win(cfg_data[WIN_CFG_W-1:0]);
        REG_PLANE_ROWS:  rows_m1_r   <= clamp_line(cfg_data[LINE_CFG_W-1:0]);
        REG_PLANE_COLS:  cols_m1_r   <= clamp_line(cfg_data[LINE_CFG_W-1:0]);
        REG_PLANE_COUNT: planes_m1_r <= clamp_plane(cfg_data);
        default:         ;
      endcase
    end
  end

  // Advance the raster position; any register write restarts the frame
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_wr_en) begin
      row_r   <= '0;
      col_r   <= '0;
      wrow_r  <= '0;
      wcol_r  <= '0;
      riw_r   <= '0;
      ciw_r   <= '0;
      plane_r <= '0;
    end else if (in_fire) begin
      if (col_r == cols_m1_r) begin
        col_r  <= '0;
        ciw_r  <= '0;
        wcol_r <= '0;
        if (row_r == rows_m1_r) begin
          row_r   <= '0;
          riw_r   <= '0;
          wrow_r  <= '0;
          plane_r <= (plane_r == planes_m1_r) ? '0 : plane_r + 1'b1;
        end else begin
          row_r <= row_r + 1'b1;
          if (riw_r == win_m1_r) begin
            riw_r  <= '0;
            wrow_r <= wrow_r + 1'b1;
          end else begin
            riw_r <= riw_r + 1'b1;
          end
        end
      end else begin
        col_r <= col_r + 1'b1;
        if (ciw_r == win_m1_r) begin
          ciw_r  <= '0;
          wcol_r <= wcol_r + 1'b1;
        end else begin
          ciw_r <= ciw_r + 1'b1;
        end
      end
    end
  end

  // Input stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  // Capture the sample and its window position
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_sample_r   <= in_sample;
      s1_slot_r     <= wcol_r;
      s1_riw_r      <= riw_r;
      s1_ciw_r      <= ciw_r;
      s1_seed_r     <= (riw_r == '0) && (ciw_r == '0);
      s1_last_r     <= last_row && last_col;
      s1_base_row_r <= row_r - CW'(riw_r);
      s1_base_col_r <= col_r - CW'(ciw_r);
      s1_wrow_r     <= wrow_r;
      s1_plane_r    <= plane_r;
      byp_hit_r     <= s1_adv && (s1_slot_r == wcol_r);
      byp_word_r    <= new_word;
    end
  end

  // Line store: read on accept, write back when the stage advances
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      line_mem[s1_slot_r] <= new_word;
    end
    if (in_fire) begin
      rd_word_r <= line_mem[wcol_r];
    end
  end

  // Update the running maximum; ties keep the stored one
  always_comb begin
    old_word = byp_hit_r ? byp_word_r : rd_word_r;
    old_val  = old_word[MW-1 -: VAL_W];
    if (s1_seed_r) begin
      new_val     = s1_sample_r;
      new_off_row = '0;
      new_off_col = '0;
    end else if (s1_sample_r > old_val) begin
      new_val     = s1_sample_r;
      new_off_row = s1_riw_r;
      new_off_col = s1_ciw_r;
    end else begin
      new_val     = old_val;
      new_off_row = old_word[2*WW-1 -: WW];
      new_off_col = old_word[WW-1:0];
    end
    new_word = {new_val, new_off_row, new_off_col};
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Load the result of a finished window
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_value_r <= new_val;
      out_prow_r  <= COORD_W'(s1_wrow_r);
      out_pcol_r  <= COORD_W'(s1_slot_r);
      out_plane_r <= s1_plane_r;
      out_srow_r  <= COORD_W'(s1_base_row_r + CW'(new_off_row));
      out_scol_r  <= COORD_W'(s1_base_col_r + CW'(new_off_col));
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pooled_value = out_value_r;
  assign out_pooled_row   = out_prow_r;
  assign out_pooled_col   = out_pcol_r;
  assign out_plane_index  = out_plane_r;
  assign out_source_row   = out_srow_r;
  assign out_source_col   = out_scol_r;

  // Checks
  `ASSERT_CLK(a_no_overwrite, out_load |-> (!out_valid_r || out_ready), "result overwritten")
  `ASSERT_CLK(a_pos_in_plane, (row_r <= rows_m1_r) && (col_r <= cols_m1_r), "position outside plane")
  `ASSERT_CLK(a_pos_in_window, (riw_r <= win_m1_r) && (ciw_r <= win_m1_r), "position outside window")
  `ASSERT_CLK(a_col_start, (col_r == '0) |-> (ciw_r == '0) && (wcol_r == '0), "window column out of step")
  `ASSERT_CLK(a_out_source, $rose(out_valid_r) |-> $past(s1_valid_r && s1_last_r), "result without finished window")

endmodule

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// Max pooling with argmax unit testbench
// Streams samples under a series of register settings into the pooling unit.
// A local predictor of the line store and position counters computes every
// expected window result, and the monitor checks each result field by field.
// ----------------------------------------------------------------------------
module testbench;
  import mpwa_pkg::*;

  localparam int LINE_DEPTH    = 1024;
  localparam int WIN_MAX       = 8;
  localparam int MAX_GAP       = 7;
  localparam int SETTLE_CYCLES = 8;
  localparam int RUN_LIMIT     = 3000000;
  // fixed sample value mixed into the directed and random stimulus
  localparam logic signed [VAL_W-1:0] SEED_MARK = -16'sd1526;

  typedef struct {
    logic signed [VAL_W-1:0] value;
    logic [COORD_W-1:0]      prow;
    logic [COORD_W-1:0]      pcol;
    logic [PLANE_W-1:0]      plane;
    logic [COORD_W-1:0]      srow;
    logic [COORD_W-1:0]      scol;
  } window_max_t;

  // DUT inputs, known from time zero
  logic                    clk       = 1'b0;
  logic                    rst_n     = 1'b0;
  logic                    cfg_wr_en = 1'b0;
  cfg_reg_t                cfg_index = REG_WINDOW_SIZE;
  logic [CFG_DATA_W-1:0]   cfg_data  = '0;
  logic                    in_valid  = 1'b0;
  logic signed [VAL_W-1:0] in_sample = '0;
  logic                    out_ready = 1'b0;

  // DUT outputs
  logic                    in_ready;
  logic                    out_valid;
  logic signed [VAL_W-1:0] out_pooled_value;
  logic [COORD_W-1:0]      out_pooled_row;
  logic [COORD_W-1:0]      out_pooled_col;
  logic [PLANE_W-1:0]      out_plane_index;
  logic [COORD_W-1:0]      out_source_row;
  logic [COORD_W-1:0]      out_source_col;

  // stimulus and checking state
  logic signed [VAL_W-1:0] sample_queue [$];
  window_max_t             pooled_expected [$];
  bit                      in_taken;
  bit                      out_taken;
  bit                      steady_flow;
  int                      in_gap;
  int                      out_stall;
  int                      mismatches;
  int                      results_checked;
  int                      samples_taken;
  int                      settings_applied;

  // predictor copy of the registers, counters and line store
  int unsigned             win_reg    = 2;
  int unsigned             rows_reg   = 32;
  int unsigned             cols_reg   = 32;
  int unsigned             planes_reg = 1;
  int unsigned             row_pos;
  int unsigned             col_pos;
  int unsigned             plane_pos;
  int unsigned             row_in_win;
  int unsigned             col_in_win;
  logic signed [VAL_W-1:0] line_max     [LINE_DEPTH];
  logic [3:0]              line_row_off [LINE_DEPTH];
  logic [3:0]              line_col_off [LINE_DEPTH];

  max_pool_with_argmax_unit #(
    .MAX_LINE   (LINE_DEPTH),
    .MAX_WINDOW (WIN_MAX)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_sample        (in_sample),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pooled_value (out_pooled_value),
    .out_pooled_row   (out_pooled_row),
    .out_pooled_col   (out_pooled_col),
    .out_plane_index  (out_plane_index),
    .out_source_row   (out_source_row),
    .out_source_col   (out_source_col)
  );

  always #5 clk = ~clk;

  // Zero acts as one, large values saturate
  function automatic int unsigned sat_reg(input int unsigned v, input int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void rewind_frame();
    row_pos    = 0;
    col_pos    = 0;
    plane_pos  = 0;
    row_in_win = 0;
    col_in_win = 0;
  endfunction

  // Update the running window maximum for one sample and queue the result
  // when the sample closes its window
  task automatic advance_pool(input logic signed [VAL_W-1:0] s);
    int unsigned w, rows, cols, planes, slot;
    logic        last_r, last_c;
    window_max_t res;
    w      = sat_reg(win_reg, WIN_MAX);
    rows   = sat_reg(rows_reg, LINE_DEPTH);
    cols   = sat_reg(cols_reg, LINE_DEPTH);
    planes = sat_reg(planes_reg, PLANE_MAX);
    if (row_pos >= rows || col_pos >= cols || plane_pos >= planes ||
        row_in_win >= w || col_in_win >= w)
      rewind_frame();
    slot = (col_pos / w) % LINE_DEPTH;

    // seed on the window's first sample, replace only on a strictly larger one
    if (row_in_win == 0 && col_in_win == 0) begin
      line_max[slot]     = s;
      line_row_off[slot] = '0;
      line_col_off[slot] = '0;
    end else if (s > line_max[slot]) begin
      line_max[slot]     = s;
      line_row_off[slot] = 4'(row_in_win);
      line_col_off[slot] = 4'(col_in_win);
    end

    last_r = (row_in_win == w - 1) || (row_pos == rows - 1);
    last_c = (col_in_win == w - 1) || (col_pos == cols - 1);
    if (last_r && last_c) begin
      res.value = line_max[slot];
      res.prow  = COORD_W'(row_pos / w);
      res.pcol  = COORD_W'(col_pos / w);
      res.plane = PLANE_W'(plane_pos);
      res.srow  = COORD_W'(row_pos - row_in_win + line_row_off[slot]);
      res.scol  = COORD_W'(col_pos - col_in_win + line_col_off[slot]);
      pooled_expected.insert(pooled_expected.size(), res);
    end

    // advance raster position, wrap plane and frame
    if (col_pos == cols - 1) begin
      col_pos    = 0;
      col_in_win = 0;
      if (row_pos == rows - 1) begin
        row_pos    = 0;
        row_in_win = 0;
        plane_pos  = (plane_pos == planes - 1) ? 0 : plane_pos + 1;
      end else begin
        row_pos    = row_pos + 1;
        row_in_win = (row_in_win == w - 1) ? 0 : row_in_win + 1;
      end
    end else begin
      col_pos    = col_pos + 1;
      col_in_win = (col_in_win == w - 1) ? 0 : col_in_win + 1;
    end
  endtask

  task automatic check_field(input string field, input int expv, input int actv);
    if (expv != actv) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, expv, actv);
      mismatches++;
    end
  endtask

  // Monitor: capture both handshakes, predict on each accepted sample and
  // compare each accepted result with the oldest pending window
  always @(posedge clk) begin
    window_max_t exp_res;
    in_taken  = rst_n && in_valid && in_ready;
    out_taken = rst_n && out_valid && out_ready;
    if (in_taken) begin
      advance_pool(in_sample);
      samples_taken++;
    end
    if (out_taken) begin
      if (pooled_expected.size() == 0) begin
        $display("%0t: result with no window pending: expected none, got value %0d",
                 $time, out_pooled_value);
        mismatches++;
      end else begin
        exp_res = pooled_expected.pop_front();
        check_field("pooled_value", int'(exp_res.value), int'(out_pooled_value));
        check_field("pooled_row", int'(exp_res.prow), int'(out_pooled_row));
        check_field("pooled_col", int'(exp_res.pcol), int'(out_pooled_col));
        check_field("plane_index", int'(exp_res.plane), int'(out_plane_index));
        check_field("source_row", int'(exp_res.srow), int'(out_source_row));
        check_field("source_col", int'(exp_res.scol), int'(out_source_col));
        results_checked++;
      end
    end
  end

  // Driver: hold each item until taken, then wait a drawn gap before the next
  always @(negedge clk) begin
    if (rst_n && !(in_valid && !in_taken)) begin
      if (in_taken)
        in_gap = steady_flow ? 0 : $urandom_range(0, MAX_GAP);
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (sample_queue.size() > 0) begin
        in_valid  <= 1'b1;
        in_sample <= sample_queue.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side: stall a drawn number of cycles after each taken result
  always @(negedge clk) begin
    if (out_taken)
      out_stall = steady_flow ? 0 : $urandom_range(0, MAX_GAP);
    if (out_stall > 0) begin
      out_stall--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_WINDOW_SIZE: win_reg    = data[WIN_CFG_W-1:0];
      REG_PLANE_ROWS:  rows_reg   = data[LINE_CFG_W-1:0];
      REG_PLANE_COLS:  cols_reg   = data[LINE_CFG_W-1:0];
      REG_PLANE_COUNT: planes_reg = data;
      default: ;
    endcase
    rewind_frame();
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic program_regs(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] r,
                              input logic [CFG_DATA_W-1:0] c, input logic [CFG_DATA_W-1:0] p);
    write_reg(REG_WINDOW_SIZE, w);
    write_reg(REG_PLANE_ROWS, r);
    write_reg(REG_PLANE_COLS, c);
    write_reg(REG_PLANE_COUNT, p);
    settings_applied++;
  endtask

  // Mix extremes, near-ties and the marker value into random samples
  function automatic logic signed [VAL_W-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      2:       return 16'(int'($urandom_range(0, 3)) - 2);
      3:       return SEED_MARK;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic feed_samples(input int n);
    repeat (n) sample_queue.insert(sample_queue.size(), pick_sample());
  endtask

  // Hold until every sample is taken and every window result has arrived,
  // then let the pipeline settle
  task automatic wait_until_idle();
    do @(posedge clk);
    while (sample_queue.size() != 0 || in_valid || pooled_expected.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    logic signed [VAL_W-1:0] directed [22];
    int n_items;
    logic [CFG_DATA_W-1:0] w_data, r_data, c_data, p_data;

    directed = '{
      16'sh8000, 16'sh8000, SEED_MARK, 16'sh8000, 16'sh8000, SEED_MARK,
      -16'sd1, 16'sd0, 16'sh7FFF,
      SEED_MARK, 16'sd100, 16'sd7, 16'sd100, 16'sh7FFF, 16'sh8000,
      16'sh7FFF, 16'sh7FFF, 16'sh8000,
      -16'sd2, -16'sd1, 16'sd0, 16'sd1
    };

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: 2x2 windows over 32x32, one plane
    steady_flow = 1'b1;
    feed_samples(40);
    wait_until_idle();

    // 3x3 planes: partial right and bottom windows, ties, extremes,
    // two planes so the frame wraps into plane 0
    steady_flow = 1'b0;
    program_regs(2, 3, 3, 2);
    foreach (directed[i]) sample_queue.insert(sample_queue.size(), directed[i]);
    wait_until_idle();

    // zero registers act as one; bits above each register width are dropped
    program_regs(13'h1FF0, 0, 13'h1800, 0);
    feed_samples(12);
    wait_until_idle();

    // random small settings, paused mid-frame until drained
    repeat (5) begin
      w_data = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : $urandom_range(1, WIN_MAX);
      r_data = $urandom_range(0, 12);
      c_data = $urandom_range(0, 12);
      p_data = $urandom_range(0, 3);
      program_regs(w_data, r_data, c_data, p_data);
      steady_flow = ($urandom_range(0, 3) == 0);
      n_items = $urandom_range(8, 20);
      feed_samples(n_items / 2);
      wait_until_idle();
      feed_samples(n_items - n_items / 2);
      wait_until_idle();
    end

    // tall planes: row count and window side saturate
    steady_flow = 1'b0;
    program_regs(9, 2047, 3, 2);
    feed_samples(24);
    wait_until_idle();

    // largest exact settings, first row band only
    program_regs(WIN_MAX, LINE_DEPTH, LINE_DEPTH, PLANE_MAX);
    feed_samples(16);
    wait_until_idle();

    // one full-width row: column count and plane count saturate
    program_regs(15, 0, 2047, 8191);
    feed_samples(1026);
    wait_until_idle();

    $display("Pooled %0d samples under %0d register settings, %0d window results checked.",
             samples_taken, settings_applied, results_checked);
    $display("Settings spanned zero, saturating and largest exact values, edges and wraps.");
    if (mismatches == 0 && pooled_expected.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // End a hung run
  initial begin : watchdog
    #(RUN_LIMIT);
    $display("Timed out with %0d window results outstanding.", pooled_expected.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
